@@ hdl/transno_age_slot_table_macros.svh @@
// Assertion helpers for the age slot table
`ifndef TRANSNO_AGE_SLOT_TABLE_MACROS_SVH
`define TRANSNO_AGE_SLOT_TABLE_MACROS_SVH

// same-cycle implication, clocked on clk_i, quiet in reset
`define TAST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tast: check failed");

// next-cycle implication
`define TAST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tast: check failed");

`endif

@@ hdl/tast_pkg.sv @@
package tast_pkg;

  localparam int TIME_W    = 32;
  localparam int TN_W      = 64;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int NSLOT_W   = 5;

  // request commands
  localparam logic [CMD_W-1:0] CMD_UPDATE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESCALE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STALE_AGE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_SLOTS = 1'd1;

  localparam logic [NSLOT_W-1:0] NUM_SLOTS_RST = 5'd16;

endpackage

@@ hdl/transno_age_slot_table.sv @@
// Channel | dir | handshake            | payload
// in      | in  | in_valid_i/in_stall_o | command, now_seconds, new_transno,
//         |     |                       | committed_key, new_age
// out     | out | out_valid_o/out_stall_i | seen_time, slots_shifted
// cfg     | in  | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// One request at a time; the shared bit-serial divider (NW = 32 + slot bits
// wide) sets the pace. The slot memory has one valid bit per entry, so reset
// takes effect at once. A result waits in the output register while the next
// request is taken; the block stalls its input until it is back in idle.
module transno_age_slot_table import tast_pkg::*; #(
  parameter int MAX_SLOTS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [CMD_W-1:0]                      command_i,
  input  logic [TIME_W-1:0]                     now_seconds_i,
  input  logic [TN_W-1:0]                       new_transno_i,
  input  logic [TN_W-1:0]                       committed_key_i,
  input  logic [TIME_W-1:0]                     new_age_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [TIME_W-1:0]                     seen_time_o,
  output logic [$clog2(MAX_SLOTS+1)-1:0]        slots_shifted_o,
  input  logic                                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                  cfg_idx_i,
  input  logic [TIME_W-1:0]                     cfg_wdata_i
);

`include "transno_age_slot_table_macros.svh"

  localparam int SW = $clog2(MAX_SLOTS + 1);
  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int NW = TIME_W + SW;
  localparam int CW = (SW > NSLOT_W) ? SW : NSLOT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_RMUL = 4'd2;
  localparam logic [3:0] S_DGO  = 4'd3;
  localparam logic [3:0] S_DWT  = 4'd4;
  localparam logic [3:0] S_CRD  = 4'd5;
  localparam logic [3:0] S_CWR  = 4'd6;
  localparam logic [3:0] S_UFIN = 4'd7;
  localparam logic [3:0] S_SRD  = 4'd8;
  localparam logic [3:0] S_SCMP = 4'd9;
  localparam logic [3:0] S_LMUL = 4'd10;
  localparam logic [3:0] S_LSUB = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  logic [3:0]          state_q;
  logic [TIME_W-1:0]   age_q, base_q;
  logic [NSLOT_W-1:0]  nslots_q;
  logic [CMD_W-1:0]    cmd_q;
  logic [TIME_W-1:0]   now_q, nage_q, prod_q, res_seen_q, out_seen_q;
  logic [TN_W-1:0]     tn_q, key_q;
  logic [SW-1:0]       idx_q, k_q, res_shift_q, out_shift_q;
  logic                hit_q, grow_q, zero_q, out_valid_q;
  logic [NW-1:0]       n_q, mnum_q;
  logic [TIME_W-1:0]   den_q;
  logic [IW-1:0]       src_q;

  logic [TN_W-1:0]     mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] vld_q;
  logic [TN_W-1:0]     rd_data_q, rd_val;
  logic                rd_vld_q;

  logic                in_acc, out_free, div_start, div_done;
  logic [NW-1:0]       div_quot;
  logic [CW-1:0]       nsl_ext;
  logic [SW-1:0]       s_eff, s_m1;
  logic [IW-1:0]       usrc, rd_addr, wr_addr;
  logic                mem_re, mem_we;
  logic [TN_W-1:0]     wr_data;
  logic [TIME_W-1:0]   dt;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // elapsed time, wraps at 32 bits
  assign dt = now_q - base_q;

  // effective slot count
  assign nsl_ext = CW'(nslots_q);
  always_comb begin
    if (nsl_ext == '0) begin
      s_eff = SW'(1);
    end else if (nsl_ext > CW'(MAX_SLOTS)) begin
      s_eff = SW'(MAX_SLOTS);
    end else begin
      s_eff = SW'(nsl_ext);
    end
  end
  assign s_m1 = s_eff - 1'b1;

  // update source slot: i-n, or slot 0 once the gap passes it
  assign usrc = (NW'(idx_q) > n_q) ? IW'(idx_q - SW'(n_q)) : '0;

  // memory port control
  assign mem_re  = (state_q == S_CRD) || (state_q == S_SRD);
  assign rd_addr = (state_q == S_SRD) ? IW'(idx_q) :
                   ((cmd_q == CMD_UPDATE) ? usrc : src_q);
  assign mem_we  = (state_q == S_CWR) || (state_q == S_UFIN);
  assign wr_addr = (state_q == S_UFIN) ? '0 : IW'(idx_q);
  assign wr_data = (state_q == S_UFIN) ? tn_q : (zero_q ? '0 : rd_val);
  assign rd_val  = rd_vld_q ? rd_data_q : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  assign div_start = (state_q == S_DGO);

  tast_div #(.NW(NW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mnum_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q    <= '0;
      nslots_q <= NUM_SLOTS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STALE_AGE: age_q    <= cfg_wdata_i;
        REG_NUM_SLOTS: nslots_q <= cfg_wdata_i[NSLOT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // output register: set on leaving S_OUT, cleared once taken
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) state_q <= S_DISP;
        end
        S_DISP: begin
          case (cmd_q)
            CMD_UPDATE:  state_q <= (age_q == '0) ? S_OUT : S_DGO;
            CMD_LOOKUP:  state_q <= (age_q == '0) ? S_OUT : S_SRD;
            CMD_RESCALE: state_q <= (age_q == '0) ? S_OUT : S_RMUL;
            default:     state_q <= S_OUT;
          endcase
        end
        S_RMUL: state_q <= S_DGO;
        S_DGO:  state_q <= S_DWT;
        S_DWT: begin
          if (div_done) begin
            case (cmd_q)
              CMD_UPDATE: begin
                if (div_quot == '0)          state_q <= S_OUT;
                else if (s_m1 == '0)         state_q <= S_UFIN;
                else                         state_q <= S_CRD;
              end
              CMD_LOOKUP: state_q <= S_LMUL;
              default: begin
                if (div_quot >= NW'(s_eff) && !grow_q) begin
                  state_q <= (idx_q == '0) ? S_OUT : S_RMUL;
                end else begin
                  state_q <= S_CRD;
                end
              end
            endcase
          end
        end
        S_CRD: state_q <= S_CWR;
        S_CWR: begin
          if (cmd_q == CMD_UPDATE) begin
            state_q <= (idx_q == SW'(1)) ? S_UFIN : S_CRD;
          end else if (grow_q) begin
            state_q <= (idx_q == s_m1) ? S_OUT : S_RMUL;
          end else begin
            state_q <= (idx_q == '0) ? S_OUT : S_RMUL;
          end
        end
        S_UFIN: begin
          base_q  <= now_q;
          state_q <= S_OUT;
        end
        S_SRD: state_q <= S_SCMP;
        S_SCMP: begin
          if (idx_q != s_m1)                          state_q <= S_SRD;
          else if (hit_q || key_q <= rd_val)          state_q <= S_DGO;
          else                                        state_q <= S_OUT;
        end
        S_LMUL: state_q <= S_LSUB;
        S_LSUB: state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_q  <= command_i;
          now_q  <= now_seconds_i;
          tn_q   <= new_transno_i;
          key_q  <= committed_key_i;
          nage_q <= new_age_i;
        end
      end
      S_DISP: begin
        res_seen_q  <= (cmd_q == CMD_LOOKUP && age_q == '0) ? now_q : '0;
        res_shift_q <= '0;
        hit_q       <= 1'b0;
        grow_q      <= age_q < nage_q;
        idx_q       <= (cmd_q == CMD_RESCALE && !(age_q < nage_q)) ? s_m1 : '0;
        mnum_q      <= NW'(dt) * NW'(s_eff);
        den_q       <= age_q;
      end
      S_RMUL: begin
        mnum_q <= NW'(idx_q) * NW'(nage_q);
        den_q  <= age_q;
      end
      S_DWT: begin
        if (div_done) begin
          n_q    <= div_quot;
          src_q  <= IW'(div_quot);
          zero_q <= (cmd_q == CMD_RESCALE) && (div_quot >= NW'(s_eff));
          if (cmd_q == CMD_UPDATE) begin
            idx_q <= s_m1;
          end else if (cmd_q == CMD_RESCALE && div_quot >= NW'(s_eff) && !grow_q) begin
            idx_q <= idx_q - 1'b1;
          end
        end
      end
      S_CWR: begin
        if (cmd_q == CMD_UPDATE || !grow_q) begin
          idx_q <= idx_q - 1'b1;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      S_UFIN: begin
        res_shift_q <= (n_q > NW'(MAX_SLOTS)) ? SW'(MAX_SLOTS) : SW'(n_q);
      end
      S_SCMP: begin
        if (key_q <= rd_val) begin
          k_q   <= idx_q;
          hit_q <= 1'b1;
        end
        if (idx_q != s_m1) begin
          idx_q <= idx_q + 1'b1;
        end else begin
          res_seen_q <= now_q;
          mnum_q     <= NW'(age_q);
          den_q      <= TIME_W'(s_eff);
        end
      end
      S_LMUL: prod_q <= div_quot[TIME_W-1:0] * TIME_W'(k_q);
      S_LSUB: res_seen_q <= base_q - prod_q;
      S_OUT: begin
        if (out_free) begin
          out_seen_q  <= res_seen_q;
          out_shift_q <= res_shift_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign seen_time_o     = out_seen_q;
  assign slots_shifted_o = out_shift_q;

  `TAST_ASSERT_NXT(a_acc_disp, in_acc, state_q == S_DISP)
  `TAST_ASSERT_NOW(a_div_wait, div_done, state_q == S_DWT)
  `TAST_ASSERT_NOW(a_we_state, mem_we, cmd_q != CMD_LOOKUP)
  `TAST_ASSERT_NXT(a_out_load, (state_q == S_OUT) && out_free,
                   out_valid_o && (state_q == S_IDLE))

endmodule

@@ hdl/tast_div.sv @@
// Restoring divider, one quotient bit per cycle
module tast_div import tast_pkg::*; #(
  parameter int NW = 37
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NW-1:0]     num_i,
  input  logic [TIME_W-1:0] den_i,
  output logic              done_o,
  output logic [NW-1:0]     quot_o
);

  localparam int CNTW = $clog2(NW + 1);

  logic [CNTW-1:0]   cnt_q;
  logic              busy_q, done_q;
  logic [TIME_W-1:0] rem_q;
  logic [NW-1:0]     quo_q;
  logic [TIME_W-1:0] den_q;
  logic [TIME_W:0]   shifted, diff;
  logic              ge;

  // trial subtract
  assign shifted = {rem_q, quo_q[NW-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
